// ===== hw/rtl/prgf_pkg.sv =====
// ----------------------------------------------------------------------------
// prgf_pkg
// Shared types, codes and helpers for the priority rectangle grid fill core.
// ----------------------------------------------------------------------------
package prgf_pkg;

	localparam int FIELD_W = 12;   // width of one packed rectangle field
	localparam int CELL_W  = 6;    // width of a stored cell type id
	localparam int RECT_W  = 60;   // packed rectangle word

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_LOAD  = 2'd1,
		MODE_DRAW  = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_ACTIVE_COLS = 2'd0,
		REG_ACTIVE_ROWS = 2'd1,
		REG_MAX_TYPE_ID = 2'd2
	} reg_idx_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;     // latch the input transaction
		logic clr_step;    // write zero at the clear pointer
		logic load_entry;  // write one table entry
		logic setup;       // clamp rectangle, look up new type
		logic start_draw;  // init sweep counters
		logic sweep;       // issue one cell read-modify-write
		logic read_cell;   // issue cell read
		logic read_take;   // latch read data into result
		logic out_load;    // move result to output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic sweep_last;
		logic skip;
		logic out_free;
	} sts_t;

	function automatic logic [FIELD_W-1:0] clamp_hi(input logic [FIELD_W-1:0] v,
		input logic [FIELD_W-1:0] hi);
		return (v > hi) ? hi : v;
	endfunction

endpackage

// ===== hw/rtl/prgf_ctrl.sv =====
// ----------------------------------------------------------------------------
// prgf_ctrl
// Sequencer: decodes the transaction mode and steps the datapath through it.
// ----------------------------------------------------------------------------
module prgf_ctrl import prgf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  mode_t mode,
	input  sts_t  sts,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_LOAD,
		ST_SETUP,
		ST_SETUP2,
		ST_DRAW,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_READ,
		ST_READ2,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   rdy_q;

	assign s_tready = rdy_q;

	always_comb begin
		cmd         = '0;
		cmd.capture = rdy_q & s_tvalid;
		unique case (state_q)
			ST_INIT, ST_CLEAR: cmd.clr_step   = 1'b1;
			ST_LOAD:           cmd.load_entry = 1'b1;
			ST_SETUP:          cmd.setup      = 1'b1;
			ST_SETUP2:         cmd.start_draw = 1'b1;
			ST_DRAW:           cmd.sweep      = 1'b1;
			ST_READ:           cmd.read_cell  = 1'b1;
			ST_READ2:          cmd.read_take  = 1'b1;
			ST_FINISH:         cmd.out_load   = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			rdy_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
						rdy_q   <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (cmd.capture) begin
						rdy_q <= 1'b0;
						unique case (mode)
							MODE_CLEAR: state_q <= ST_CLEAR;
							MODE_LOAD:  state_q <= ST_LOAD;
							MODE_DRAW:  state_q <= ST_SETUP;
							MODE_READ:  state_q <= ST_READ;
							default:    state_q <= ST_FINISH;
						endcase
					end
				end
				ST_CLEAR:  if (sts.clr_last) state_q <= ST_FINISH;
				ST_LOAD:   state_q <= ST_FINISH;
				ST_SETUP:  state_q <= ST_SETUP2;
				ST_SETUP2: state_q <= sts.skip ? ST_FINISH : ST_DRAW;
				ST_DRAW:   if (sts.sweep_last) state_q <= ST_DRAIN1;
				ST_DRAIN1: state_q <= ST_DRAIN2;
				ST_DRAIN2: state_q <= ST_FINISH;
				ST_READ:   state_q <= ST_READ2;
				ST_READ2:  state_q <= ST_FINISH;
				ST_FINISH: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
						rdy_q   <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					rdy_q   <= 1'b1;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/prgf_dp.sv =====
// ----------------------------------------------------------------------------
// prgf_dp
// Datapath: grid memory, type table, sweep counters, cell pipeline, result.
// ----------------------------------------------------------------------------
module prgf_dp import prgf_pkg::*; #(
	parameter int MAX_ROWS      = 32,
	parameter int MAX_COLS      = 32,
	parameter int TYPE_COUNT    = 64,
	parameter int PRIORITY_BITS = 8,
	parameter int FIELD_BITS    = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [RECT_W-1:0] rect_word,
	input  logic [5:0]        entry_id,
	input  logic [7:0]        entry_priority,
	input  logic              entry_present,
	input  logic [4:0]        cell_row,
	input  logic [4:0]        cell_col,
	input  logic [5:0]        active_cols,
	input  logic [5:0]        active_rows,
	input  logic [5:0]        max_type_id,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [CELL_W-1:0] cell_type
);

	localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int GAW        = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
	localparam int XW         = $clog2(MAX_COLS + 1);
	localparam int YW         = $clog2(MAX_ROWS + 1);
	localparam int TBL_DEPTH  = (TYPE_COUNT < (1 << CELL_W)) ? TYPE_COUNT : (1 << CELL_W);
	localparam int TAW        = $clog2(TBL_DEPTH);
	localparam int PSW        = (PRIORITY_BITS < 8) ? PRIORITY_BITS : 8;

	// captured transaction
	logic [RECT_W-1:0] rect_q;
	logic [5:0]        eid_q;
	logic [PSW-1:0]    epri_q;
	logic              epres_q;
	logic [4:0]        row_q;
	logic [4:0]        col_q;

	// type table
	logic [PSW-1:0]       prio_mem [TBL_DEPTH];
	logic [TBL_DEPTH-1:0] present_q;
	logic [TAW-1:0]       prio_raddr;
	logic [PSW-1:0]       prio_rd_q;

	// grid
	logic [CELL_W-1:0] grid_mem [GRID_DEPTH];
	logic [GAW-1:0]    g_raddr;
	logic [GAW-1:0]    g_waddr;
	logic [CELL_W-1:0] g_wdata;
	logic              g_we;
	logic [CELL_W-1:0] g_rdata_q;
	logic [GAW-1:0]    clr_q;

	// rectangle and sweep
	logic [FIELD_W-1:0] cols_lim, rows_lim, t_clamp;
	logic [CELL_W-1:0]  t_raw, t_fin;
	logic               t_ok;
	logic [XW-1:0]      x1_q, x2_q, x_q, x_nx;
	logic [YW-1:0]      y1_q, y2_q, y_q, y_nx;
	logic [GAW-1:0]     base_q, sweep_addr;
	logic [CELL_W-1:0]  t_q;
	logic               npres_q;
	logic [PSW-1:0]     new_prio, np_q;
	logic               x_end;

	// cell pipeline
	logic           v_s1, v_s2;
	logic [GAW-1:0] a_s1, a_s2;
	logic           pres_s2;
	logic [PSW-1:0] old_prio;

	// cell read and result
	logic [31:0]       rd_lin;
	logic              in_grid;
	logic [CELL_W-1:0] res_q;
	logic              m_tvalid_q;
	logic [CELL_W-1:0] m_data_q;
	logic              out_free;

	function automatic logic is_present(input logic [CELL_W-1:0] id,
		input logic [TBL_DEPTH-1:0] flags);
		return (32'(id) < TBL_DEPTH) && flags[id[TAW-1:0]];
	endfunction

	// --- capture ---
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rect_q  <= rect_word;
			eid_q   <= entry_id;
			epri_q  <= entry_priority[PSW-1:0];
			epres_q <= entry_present;
			row_q   <= cell_row;
			col_q   <= cell_col;
		end
	end

	// --- type table ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (cmd.load_entry && (32'(eid_q) < TBL_DEPTH)) begin
			present_q[eid_q[TAW-1:0]] <= epres_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_entry && (32'(eid_q) < TBL_DEPTH))
			prio_mem[eid_q[TAW-1:0]] <= epri_q;
		prio_rd_q <= prio_mem[prio_raddr];
	end

	// --- rectangle setup ---
	assign cols_lim = clamp_hi(FIELD_W'(active_cols), FIELD_W'(MAX_COLS));
	assign rows_lim = clamp_hi(FIELD_W'(active_rows), FIELD_W'(MAX_ROWS));
	assign t_clamp  = clamp_hi(FIELD_W'(rect_q[4*FIELD_BITS +: FIELD_BITS]),
		FIELD_W'(max_type_id));
	assign t_raw    = t_clamp[CELL_W-1:0];
	assign t_ok     = is_present(t_raw, present_q);
	assign t_fin    = t_ok ? t_raw : '0;

	// table port: new type during setup, stored cell type during the sweep
	assign prio_raddr = cmd.setup ? t_fin[TAW-1:0] : g_rdata_q[TAW-1:0];

	assign new_prio = npres_q ? prio_rd_q : '0;
	assign sts.skip = (x1_q >= x2_q) || (y1_q >= y2_q) || (new_prio == '0);

	assign x_nx       = x_q + XW'(1);
	assign y_nx       = y_q + YW'(1);
	assign x_end      = (x_nx == x2_q);
	assign sweep_addr = base_q + GAW'(x_q);

	assign sts.sweep_last = x_end && (y_nx == y2_q);

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			x1_q <= XW'(clamp_hi(FIELD_W'(rect_q[0*FIELD_BITS +: FIELD_BITS]), cols_lim));
			y1_q <= YW'(clamp_hi(FIELD_W'(rect_q[1*FIELD_BITS +: FIELD_BITS]), rows_lim));
			x2_q <= XW'(clamp_hi(FIELD_W'(rect_q[2*FIELD_BITS +: FIELD_BITS]), cols_lim));
			y2_q <= YW'(clamp_hi(FIELD_W'(rect_q[3*FIELD_BITS +: FIELD_BITS]), rows_lim));
			t_q     <= t_fin;
			npres_q <= t_ok | is_present('0, present_q);
		end
		if (cmd.start_draw) begin
			np_q   <= new_prio;
			x_q    <= x1_q;
			y_q    <= y1_q;
			base_q <= GAW'(32'(y1_q) * 32'(MAX_COLS));
		end else if (cmd.sweep) begin
			if (x_end) begin
				x_q    <= x1_q;
				y_q    <= y_nx;
				base_q <= base_q + GAW'(MAX_COLS);
			end else begin
				x_q <= x_nx;
			end
		end
	end

	// --- cell pipeline: s1 has grid data, s2 has old priority ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.sweep;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= sweep_addr;
		a_s2    <= a_s1;
		pres_s2 <= is_present(g_rdata_q, present_q);
	end

	assign old_prio = pres_s2 ? prio_rd_q : '0;

	// --- grid memory ---
	assign rd_lin  = 32'(row_q) * 32'(MAX_COLS) + 32'(col_q);
	assign in_grid = (32'(row_q) < MAX_ROWS) && (32'(col_q) < MAX_COLS);
	assign g_raddr = cmd.read_cell ? rd_lin[GAW-1:0] : sweep_addr;

	assign g_we    = cmd.clr_step || (v_s2 && (np_q > old_prio));
	assign g_waddr = cmd.clr_step ? clr_q : a_s2;
	assign g_wdata = cmd.clr_step ? '0 : t_q;

	always_ff @(posedge clk) begin
		if (g_we)
			grid_mem[g_waddr] <= g_wdata;
		g_rdata_q <= grid_mem[g_raddr];
	end

	assign sts.clr_last = (32'(clr_q) == GRID_DEPTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= sts.clr_last ? '0 : clr_q + GAW'(1);
		end
	end

	// --- result and output register ---
	always_ff @(posedge clk) begin
		if (cmd.capture)
			res_q <= '0;
		else if (cmd.read_take)
			res_q <= in_grid ? g_rdata_q : '0;
		if (cmd.out_load)
			m_data_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign out_free     = !m_tvalid_q || m_tready;
	assign sts.out_free = out_free;
	assign m_tvalid     = m_tvalid_q;
	assign cell_type    = m_data_q;

`ifndef SYNTH
	// no new transaction while draw writes are still in flight
	a_no_capture_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> !cmd.capture)
		else $error("transaction accepted during draw drain");

	// cell read never collides with a grid write
	a_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read_cell |-> !g_we)
		else $error("grid written during cell read");

	// table stays fixed while cells are compared against it
	a_table_stable: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_entry |-> (!v_s1 && !v_s2 && !cmd.sweep))
		else $error("table loaded during draw");

	// a result is only moved into a free output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("output register overwritten");
`endif

endmodule

// ===== hw/rtl/priority_rectangle_grid_fill_core.sv =====
// ----------------------------------------------------------------------------
// priority_rectangle_grid_fill_core
// Type-id grid with per-type priorities; draws rectangles under a priority rule.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream (s_*) carries one command transaction; s_tuser selects it:
//    clear grid, load table entry, draw rectangle, read cell.
//  - Master stream (m_*) returns one transaction per command: the cell type
//    for a read, zero otherwise.
//  - APB port holds active_cols (0x0), active_rows (0x4), max_type_id (0x8);
//    write only while the core is idle.
//  - One command at a time; the next is accepted in the cycle after the result
//    is loaded. A draw sweeps the cells in the clamped rectangle (one grid
//    read-modify-write per cycle through the single-write grid RAM), or skips
//    the sweep if nothing is to be drawn.
//  - After reset the grid RAM is swept to zero, MAX_ROWS*MAX_COLS cells
//    (1024 by default); s_tready stays low until that pass ends.
//  - The result sits in an output register, so the next command is accepted
//    while it waits; if m_tready stays low, the following command completes
//    its work and then holds until the register is free.
// ----------------------------------------------------------------------------
module priority_rectangle_grid_fill_core import prgf_pkg::*; #(
	parameter int MAX_ROWS      = 32,
	parameter int MAX_COLS      = 32,
	parameter int TYPE_COUNT    = 64,
	parameter int PRIORITY_BITS = 8,
	parameter int FIELD_BITS    = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	// command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [59:0] rect_word, [65:60] entry_id, [73:66] entry_priority,
	// [74] entry_present, [79:75] cell_row, [84:80] cell_col, [87:85] zero
	input  logic [87:0] s_tdata,
	// [1:0] mode
	input  logic [1:0]  s_tuser,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [5:0] cell_type, [7:6] zero
	output logic [7:0]  m_tdata,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cmd_t              cmd;
	sts_t              sts;
	logic [5:0]        cols_q;
	logic [5:0]        rows_q;
	logic [5:0]        maxt_q;
	logic [CELL_W-1:0] cell_type;
	reg_idx_t          reg_sel;

	// --- configuration registers ---
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 6'd32;
			rows_q <= 6'd32;
			maxt_q <= 6'd63;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_ACTIVE_COLS: cols_q <= pwdata[5:0];
				REG_ACTIVE_ROWS: rows_q <= pwdata[5:0];
				REG_MAX_TYPE_ID: maxt_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_ACTIVE_COLS: prdata = {26'd0, cols_q};
			REG_ACTIVE_ROWS: prdata = {26'd0, rows_q};
			REG_MAX_TYPE_ID: prdata = {26'd0, maxt_q};
			default:         prdata = '0;
		endcase
	end

	// --- sequencer ---
	prgf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.mode     (mode_t'(s_tuser)),
		.sts      (sts),
		.cmd      (cmd)
	);

	// --- grid, table and result path ---
	prgf_dp #(
		.MAX_ROWS      (MAX_ROWS),
		.MAX_COLS      (MAX_COLS),
		.TYPE_COUNT    (TYPE_COUNT),
		.PRIORITY_BITS (PRIORITY_BITS),
		.FIELD_BITS    (FIELD_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.rect_word      (s_tdata[59:0]),
		.entry_id       (s_tdata[65:60]),
		.entry_priority (s_tdata[73:66]),
		.entry_present  (s_tdata[74]),
		.cell_row       (s_tdata[79:75]),
		.cell_col       (s_tdata[84:80]),
		.active_cols    (cols_q),
		.active_rows    (rows_q),
		.max_type_id    (maxt_q),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.cell_type      (cell_type)
	);

	assign m_tdata = {2'b00, cell_type};

endmodule

// ===== bench/priority_rectangle_grid_fill_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_rectangle_grid_fill_core_tb
// Self-checking bench for the priority rectangle grid fill core.
// A grid model in a small scoreboard class tracks cells, type priorities and
// present flags, predicts one cell_type per command, and checks the result
// stream in order. Directed commands cover clamping, the strict priority
// rule, absent types, empty rectangles and reads outside the active area.
// Randomized phases under several APB settings follow, with bursty input,
// a patterned output stall and one long output hold-off.
// ----------------------------------------------------------------------------
module priority_rectangle_grid_fill_core_tb import prgf_pkg::*; ();

	localparam int MAX_ROWS    = 32;
	localparam int MAX_COLS    = 32;
	localparam int TYPE_COUNT  = 64;
	localparam int GRID_CELLS  = MAX_ROWS * MAX_COLS;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int LONG_STALL  = 400;   // output hold-off, in cycles
	localparam int SETTLE      = 16;    // idle cycles before an APB write
	localparam int REPORT_MAX  = 10;

	// rect_word layout, x1 in the low bits
	typedef struct packed {
		logic [FIELD_W-1:0] type_id;
		logic [FIELD_W-1:0] y2;
		logic [FIELD_W-1:0] x2;
		logic [FIELD_W-1:0] y1;
		logic [FIELD_W-1:0] x1;
	} rect_fields_t;

	// s_tdata layout, rect in the low bits
	typedef struct packed {
		logic [2:0]   pad;
		logic [4:0]   cell_col;
		logic [4:0]   cell_row;
		logic         entry_present;
		logic [7:0]   entry_priority;
		logic [5:0]   entry_id;
		rect_fields_t rect;
	} command_word_t;

	// ------------------------------------------------------------------------
	// Grid model and in-order result checker
	// ------------------------------------------------------------------------
	class grid_scoreboard;
		logic [CELL_W-1:0] cells [GRID_CELLS];
		logic [7:0]        prio_table [TYPE_COUNT];
		bit                present [TYPE_COUNT];
		int unsigned       cols_limit;
		int unsigned       rows_limit;
		int unsigned       max_type;
		logic [CELL_W-1:0] expected_types [$];
		int                mismatches;
		int                results_checked;
		int                issued [4];

		function new();
			foreach (cells[i]) cells[i] = '0;
			foreach (prio_table[i]) begin
				prio_table[i] = '0;
				present[i]    = 1'b0;
			end
			foreach (issued[i]) issued[i] = 0;
			cols_limit      = 32;
			rows_limit      = 32;
			max_type        = 63;
			mismatches      = 0;
			results_checked = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [5:0] value);
			case (idx)
				REG_ACTIVE_COLS: cols_limit = value;
				REG_ACTIVE_ROWS: rows_limit = value;
				REG_MAX_TYPE_ID: max_type   = value;
				default: ;
			endcase
		endfunction

		function int unsigned clip(int unsigned v, int unsigned hi);
			return (v > hi) ? hi : v;
		endfunction

		// absent or out-of-table types rank lowest
		function int unsigned rank_of(int unsigned t);
			return (t < TYPE_COUNT && present[t]) ? prio_table[t] : 0;
		endfunction

		function void paint_rect(rect_fields_t r);
			int unsigned cols, rows, x1, y1, x2, y2, t, p;
			cols = clip(cols_limit, MAX_COLS);
			rows = clip(rows_limit, MAX_ROWS);
			x1   = clip(r.x1, cols);
			y1   = clip(r.y1, rows);
			x2   = clip(r.x2, cols);
			y2   = clip(r.y2, rows);
			t    = clip(r.type_id, max_type);
			if (t >= TYPE_COUNT || !present[t]) t = 0;
			p = rank_of(t);
			for (int unsigned y = y1; y < y2; y++)
				for (int unsigned x = x1; x < x2; x++)
					if (p > rank_of(cells[y * MAX_COLS + x]))
						cells[y * MAX_COLS + x] = CELL_W'(t);
		endfunction

		// apply one accepted command, queue the cell_type it must return
		function void note_command(mode_t m, command_word_t c);
			logic [CELL_W-1:0] result;
			result = '0;
			issued[int'(m)]++;
			case (m)
				MODE_CLEAR: foreach (cells[i]) cells[i] = '0;
				MODE_LOAD: begin
					prio_table[c.entry_id] = c.entry_priority;
					present[c.entry_id]    = c.entry_present;
				end
				MODE_DRAW: paint_rect(c.rect);
				MODE_READ: result = cells[c.cell_row * MAX_COLS + c.cell_col];
				default: ;
			endcase
			expected_types.push_back(result);
		endfunction

		function void check_result(logic [CELL_W-1:0] got);
			logic [CELL_W-1:0] want;
			results_checked++;
			if (expected_types.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result %0d: cell_type=%0d with no command outstanding",
						results_checked, got);
				return;
			end
			want = expected_types.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result %0d: cell_type expected %0d, got %0d",
						results_checked, want, got);
			end
		endfunction

		function int outstanding();
			return expected_types.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT connections; every input starts at a known value
	// ------------------------------------------------------------------------
	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	grid_scoreboard board;
	int          cycle_count     = 0;
	bit          long_stall_req  = 1'b0;   // main asks the sink for a hold-off
	bit          gaps_on         = 1'b0;
	int          burst_left      = 1;
	int          settings_tried  = 0;

	priority_rectangle_grid_fill_core #(
		.MAX_ROWS     (MAX_ROWS),
		.MAX_COLS     (MAX_COLS),
		.TYPE_COUNT   (TYPE_COUNT),
		.PRIORITY_BITS(8),
		.FIELD_BITS   (FIELD_W)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Result sink: checks every transaction, stalls on a rotating pattern.
	// A hold-off request drops tready for the LONG_STALL hold-off so the core's
	// output register fills and s_tready falls while commands keep coming.
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int hold_left;
		int style;
		int window;
		hold_left = 0;
		style     = 0;
		window    = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				board.check_result(m_tdata[CELL_W-1:0]);
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				hold_left      = LONG_STALL;
			end
			if (window == 0) begin
				style  = $urandom_range(0, 3);
				window = $urandom_range(20, 150);
			end
			window--;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (style)
					0: m_tready <= 1'b1;                           // no stalls
					1: m_tready <= 1'($urandom_range(0, 1));       // coin flip
					2: m_tready <= ($urandom_range(0, 7) != 0);    // rare stalls
					default: m_tready <= (window % 12) < 4;        // long low runs
				endcase
			end
		end
	end

	// watchdog: a hung handshake or lost result ends here
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_count, board.outstanding());
		$display("[priority_rectangle_grid_fill_core] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// one command transaction; with gaps_on the sender idles between random bursts
	task automatic send_command(mode_t m, command_word_t c);
		s_tuser  <= m;
		s_tdata  <= c;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		board.note_command(m, c);
		if (gaps_on) begin
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 24);
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	// stop sending and wait out every outstanding result
	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB write: setup, access, then idle with psel low
	task automatic write_reg(reg_idx_t idx, logic [5:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {26'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		board.set_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic apply_settings(int cols, int rows, int max_id);
		settle();
		write_reg(REG_ACTIVE_COLS, 6'(cols));
		write_reg(REG_ACTIVE_ROWS, 6'(rows));
		write_reg(REG_MAX_TYPE_ID, 6'(max_id));
		settings_tried++;
	endtask

	// random background so unused payload bits toggle too
	function automatic command_word_t noisy_command();
		logic [95:0]   noise;
		command_word_t c;
		noise = {$urandom, $urandom, $urandom};
		c     = noise[87:0];
		c.pad = '0;
		return c;
	endfunction

	task automatic do_clear();
		send_command(MODE_CLEAR, noisy_command());
	endtask

	task automatic do_load(int id, int prio, bit here);
		command_word_t c;
		c                = noisy_command();
		c.entry_id       = 6'(id);
		c.entry_priority = 8'(prio);
		c.entry_present  = here;
		send_command(MODE_LOAD, c);
	endtask

	task automatic do_draw(int x1, int y1, int x2, int y2, int t);
		command_word_t c;
		c              = noisy_command();
		c.rect.x1      = FIELD_W'(x1);
		c.rect.y1      = FIELD_W'(y1);
		c.rect.x2      = FIELD_W'(x2);
		c.rect.y2      = FIELD_W'(y2);
		c.rect.type_id = FIELD_W'(t);
		send_command(MODE_DRAW, c);
	endtask

	task automatic do_read(int row, int col);
		command_word_t c;
		c          = noisy_command();
		c.cell_row = 5'(row);
		c.cell_col = 5'(col);
		send_command(MODE_READ, c);
	endtask

	// most loads and draws share a few ids so priorities interact
	function automatic int pick_type_id();
		return ($urandom_range(0, 6) != 0) ? $urandom_range(0, 11) : $urandom_range(0, 63);
	endfunction

	task automatic random_draw();
		int kind, x1, y1, t;
		kind = $urandom_range(0, 19);
		t    = ($urandom_range(0, 9) != 0) ? pick_type_id() : $urandom_range(0, 4095);
		if (kind == 0) begin
			// raw 12-bit fields, mostly clamped
			do_draw($urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
		end else if (kind == 1) begin
			// near full grid, the slow case
			do_draw($urandom_range(0, 3), $urandom_range(0, 3),
				$urandom_range(28, 40), $urandom_range(28, 40), t);
		end else if (kind == 2) begin
			// reversed corners: empty rectangle
			x1 = $urandom_range(1, 33);
			y1 = $urandom_range(1, 33);
			do_draw(x1, y1, x1 - $urandom_range(1, x1), y1 + $urandom_range(0, 4), t);
		end else begin
			x1 = $urandom_range(0, 33);
			y1 = $urandom_range(0, 33);
			do_draw(x1, y1, x1 + $urandom_range(0, 7), y1 + $urandom_range(0, 7), t);
		end
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			do_clear();
		else if (pick < 23)
			do_load(pick_type_id(), $urandom_range(0, 255), $urandom_range(0, 9) != 0);
		else if (pick < 60)
			random_draw();
		else
			do_read($urandom_range(0, 31), $urandom_range(0, 31));
	endtask

	// hold_sink: request the long output hold-off a quarter of the way in
	// mid_drain: sender pauses halfway until every result is back
	task automatic run_random(int count, bit with_gaps, bit hold_sink, bit mid_drain);
		gaps_on    = with_gaps;
		burst_left = $urandom_range(1, 24);
		for (int i = 0; i < count; i++) begin
			if (hold_sink && i == count / 4)
				long_stall_req = 1'b1;
			if (mid_drain && i == count / 2)
				settle();
			random_item();
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : main
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings; s_tready stays low during the clearing pass
		gaps_on    = 1'b1;
		burst_left = 3;
		do_read(0, 0);                       // grid starts at zero
		do_load(5, 10, 1'b1);
		do_load(63, 255, 1'b1);              // top id, top priority
		do_load(7, 10, 1'b1);                // same priority as type 5
		do_draw(0, 0, 4095, 4095, 5);        // oversized, clamps to full grid
		do_read(31, 31);
		do_draw(0, 0, 10, 10, 4095);         // type clamps to max id 63
		do_read(0, 0);
		do_draw(0, 0, 32, 32, 7);            // equal or lower rank: no change
		do_draw(20, 0, 10, 32, 63);          // x1 >= x2: empty
		do_draw(0, 0, 32, 32, 9);            // absent type becomes type 0
		do_load(5, 200, 1'b0);               // type 5 now absent, ranks 0
		do_draw(0, 0, 32, 32, 7);            // replaces only the old type 5 cells
		do_read(31, 0);
		do_read(5, 5);

		// small active area: draws stay inside, reads outside see stored cells
		apply_settings(4, 4, 63);
		do_load(63, 0, 1'b0);
		do_draw(0, 0, 4095, 4095, 2);        // id 2 absent so far: nothing
		do_load(2, 255, 1'b1);
		do_draw(0, 0, 4095, 4095, 2);
		do_read(3, 3);
		do_read(4, 4);
		do_read(31, 31);

		// zero area and max id 0, then saturated sizes
		apply_settings(0, 0, 0);
		do_draw(0, 0, 32, 32, 2);
		apply_settings(63, 63, 63);
		do_draw(0, 0, 4095, 4095, 2);
		do_read(31, 31);
		do_clear();
		do_read(31, 31);

		// random phases across register settings
		apply_settings(32, 32, 63);
		run_random(110, 1'b0, 1'b0, 1'b0);
		apply_settings(17, 9, 40);
		run_random(110, 1'b1, 1'b1, 1'b0);
		apply_settings(0, 63, 0);
		run_random(50, 1'b1, 1'b0, 1'b0);
		apply_settings($urandom_range(1, 33), $urandom_range(1, 33), $urandom_range(0, 63));
		run_random(110, 1'b1, 1'b0, 1'b1);
		apply_settings(63, 63, 63);
		run_random(110, 1'b1, 1'b0, 1'b0);
		apply_settings(5, 32, 11);
		run_random(50, 1'b1, 1'b0, 1'b0);
		settle();

		$display("covered %0d clears, %0d table loads, %0d draws, %0d reads under %0d settings",
			board.issued[int'(MODE_CLEAR)], board.issued[int'(MODE_LOAD)],
			board.issued[int'(MODE_DRAW)], board.issued[int'(MODE_READ)], settings_tried);
		$display("%0d results checked, %0d mismatches, %0d cycles",
			board.results_checked, board.mismatches, cycle_count);
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("[priority_rectangle_grid_fill_core] OK");
		else
			$display("[priority_rectangle_grid_fill_core] ERROR");
		$finish;
	end

endmodule

// ===== priority_rectangle_grid_fill_core.f =====
hw/rtl/prgf_pkg.sv
hw/rtl/prgf_ctrl.sv
hw/rtl/prgf_dp.sv
hw/rtl/priority_rectangle_grid_fill_core.sv
bench/priority_rectangle_grid_fill_core_tb.sv
